@@ sv/att_pkg.sv @@
// Shared types, codes and helpers for the allocation tracking table.
`default_nettype none

package att_pkg;

  // Event commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;
  localparam logic [1:0] CMD_REPORT  = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_FREE_UNK  = 3'd2;
  localparam logic [2:0] ST_REAL_UNK  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_LEFTOVER  = 3'd5;
  localparam logic [2:0] ST_EMPTY     = 3'd6;

  // A report lists at most this many entries
  localparam int MAX_RESULTS = 32;

  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] size;
    logic [31:0] seq;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        seq_gap;
    logic [31:0] expected_seq;
    entry_t      entry;
    logic        last;
  } result_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic    valid;
    result_t res;
  } push_t;

  // Sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_RD       = 8'b0000_0010,
    S_CMP      = 8'b0000_0100,
    S_SHIFT_RD = 8'b0000_1000,
    S_SHIFT_WR = 8'b0001_0000,
    S_EMIT     = 8'b0010_0000,
    S_REP_RD   = 8'b0100_0000,
    S_REP_EMIT = 8'b1000_0000
  } state_t;

  function automatic result_t mk_res(input logic [2:0] status, input logic gap,
                                     input logic [31:0] exp, input entry_t ent,
                                     input logic last);
    result_t r;
    r.status       = status;
    r.seq_gap      = gap;
    r.expected_seq = exp;
    r.entry        = ent;
    r.last         = last;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/att_mem.sv @@
// Table storage: one write port and one registered read port.
`default_nettype none

module att_mem #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  wire logic            clk,
  input  wire logic            rd_en,
  input  wire logic [IW-1:0]   rd_addr,
  output att_pkg::entry_t      rd_data,
  input  wire logic            wr_en,
  input  wire logic [IW-1:0]   wr_addr,
  input  att_pkg::entry_t      wr_data
);
  import att_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ sv/att_seq.sv @@
// Sequencer: search, insert, compaction and report walk over the table.
`default_nettype none

module att_seq #(
  parameter int DEPTH = 32,
  parameter int IW    = 5,
  parameter int CW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_cmd,
  input  wire logic [31:0]   in_seq,
  input  wire logic [47:0]   in_addr,
  input  wire logic [47:0]   in_new_addr,
  input  wire logic [31:0]   in_size,
  input  wire logic          out_free,
  output att_pkg::push_t     push,
  output logic               rd_en,
  output logic [IW-1:0]      rd_addr,
  input  att_pkg::entry_t    rd_data,
  output logic               wr_en,
  output logic [IW-1:0]      wr_addr,
  output att_pkg::entry_t    wr_data
);
  import att_pkg::*;

  localparam int REP_MAX = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;
  localparam logic [CW-1:0] REP_LIM  = CW'(REP_MAX);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  state_t        state_r, state_nxt;
  logic [1:0]    cmd_r, cmd_nxt;
  logic [31:0]   seq_r, seq_nxt;
  logic [47:0]   addr_r, addr_nxt;
  logic [47:0]   naddr_r, naddr_nxt;
  logic [31:0]   size_r, size_nxt;
  logic [31:0]   exp_r, exp_nxt;
  logic          gap_r, gap_nxt;
  logic [31:0]   nexp_r, nexp_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  result_t       res_r, res_nxt;

  logic [CW-1:0] idx_p1;
  logic [CW-1:0] rep_n;
  logic          rep_last;
  logic          hit;
  logic          in_gap;
  logic          in_null;
  entry_t        ev_entry;

  assign idx_p1   = idx_r + 1'b1;
  assign rep_n    = (count_r > REP_LIM) ? REP_LIM : count_r;
  assign rep_last = (idx_p1 == rep_n);
  // shared address comparator
  assign hit      = (rd_data.addr == addr_r);
  assign in_gap   = (in_seq != nexp_r);
  assign in_null  = (in_addr == 48'd0) ||
                    ((in_cmd == CMD_REALLOC) && (in_new_addr == 48'd0));
  assign ev_entry = '{addr: addr_r, size: size_r, seq: seq_r};
  assign in_ready = (state_r == S_IDLE);

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    seq_nxt   = seq_r;
    addr_nxt  = addr_r;
    naddr_nxt = naddr_r;
    size_nxt  = size_r;
    exp_nxt   = exp_r;
    gap_nxt   = gap_r;
    nexp_nxt  = nexp_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    res_nxt   = res_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = idx_r[IW-1:0];
    wr_data   = rd_data;
    push.valid = 1'b0;
    push.res   = res_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          seq_nxt   = in_seq;
          addr_nxt  = in_addr;
          naddr_nxt = in_new_addr;
          size_nxt  = in_size;
          exp_nxt   = nexp_r;
          idx_nxt   = '0;
          if (in_cmd == CMD_REPORT) begin
            gap_nxt = 1'b0;
            if (count_r == '0) begin
              res_nxt   = mk_res(ST_EMPTY, 1'b0, nexp_r, '0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_REP_RD;
            end
          end else begin
            gap_nxt  = in_gap;
            nexp_nxt = in_seq + 32'd1;
            if (in_null) begin
              res_nxt   = mk_res(ST_OK, in_gap, nexp_r, '0, 1'b1);
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_RD;
            end
          end
        end
      end

      // issue a search read, or finish when the table is exhausted
      S_RD: begin
        if (idx_r == count_r) begin
          state_nxt = S_EMIT;
          case (cmd_r)
            CMD_ALLOC: begin
              if (count_r == FULL_CNT) begin
                res_nxt = mk_res(ST_FULL, gap_r, exp_r, ev_entry, 1'b1);
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[IW-1:0];
                wr_data   = ev_entry;
                count_nxt = count_r + 1'b1;
                res_nxt   = mk_res(ST_OK, gap_r, exp_r, '0, 1'b1);
              end
            end
            CMD_FREE: begin
              res_nxt = mk_res(ST_FREE_UNK, gap_r, exp_r,
                               '{addr: addr_r, size: 32'd0, seq: seq_r}, 1'b1);
            end
            default: begin
              res_nxt = mk_res(ST_REAL_UNK, gap_r, exp_r, ev_entry, 1'b1);
            end
          endcase
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_CMP;
        end
      end

      // compare the entry just read against the key
      S_CMP: begin
        if (hit) begin
          case (cmd_r)
            CMD_ALLOC: begin
              res_nxt   = mk_res(ST_DUP, gap_r, exp_r, rd_data, 1'b1);
              state_nxt = S_EMIT;
            end
            CMD_FREE: begin
              state_nxt = S_SHIFT_RD;
            end
            default: begin
              wr_en     = 1'b1;
              wr_data   = '{addr: naddr_r, size: size_r, seq: rd_data.seq};
              res_nxt   = mk_res(ST_OK, gap_r, exp_r, '0, 1'b1);
              state_nxt = S_EMIT;
            end
          endcase
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_RD;
        end
      end

      // compaction: pull the next entry down one place
      S_SHIFT_RD: begin
        if (idx_p1 >= count_r) begin
          count_nxt = count_r - 1'b1;
          res_nxt   = mk_res(ST_OK, gap_r, exp_r, '0, 1'b1);
          state_nxt = S_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_p1[IW-1:0];
          state_nxt = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_p1;
        state_nxt = S_SHIFT_RD;
      end

      S_EMIT: begin
        push.valid = 1'b1;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      // report walk, oldest entry first
      S_REP_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_REP_EMIT;
      end

      S_REP_EMIT: begin
        push.valid = 1'b1;
        push.res   = mk_res(ST_LEFTOVER, 1'b0, exp_r, rd_data, rep_last);
        if (out_free) begin
          if (rep_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = S_REP_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      nexp_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      nexp_r  <= nexp_nxt;
    end
  end

  // request payload and working registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    seq_r   <= seq_nxt;
    addr_r  <= addr_nxt;
    naddr_r <= naddr_nxt;
    size_r  <= size_nxt;
    exp_r   <= exp_nxt;
    gap_r   <= gap_nxt;
    idx_r   <= idx_nxt;
    res_r   <= res_nxt;
  end

endmodule

`default_nettype wire

@@ sv/allocation_tracking_table.sv @@
// Top level of the allocation tracking table: table memory, sequencer, output register.
`default_nettype none

// Keeps up to TABLE_DEPTH live chunks (address, size, allocation sequence) in
// insertion order. One request is handled at a time; in_stall is high from
// acceptance until its last result has been loaded into the output register.
// Each request is worked through one table entry at a time by a single
// 48-bit address comparator. The comparator sits on a table memory with one
// write port and one registered read port. A search reads each entry examined
// (S_RD) and then compares it (S_CMP); a free then moves each later entry
// down to close the gap, reading it (S_SHIFT_RD) and writing it one place
// lower (S_SHIFT_WR); a report reads (S_REP_RD) and then emits (S_REP_EMIT)
// each listed entry. On a free, the search and the compaction together pass
// over each entry once. Requests with a null address and reports on an empty
// table emit their result without reading the table. A stalled output holds
// the sequencer for as long as the stall lasts. A new request can be accepted
// while the final result still waits in the output register.
module allocation_tracking_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   in_cmd,
  input  wire logic [31:0]  in_seq,
  input  wire logic [47:0]  in_addr,
  input  wire logic [47:0]  in_new_addr,
  input  wire logic [31:0]  in_size,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0]        out_status,
  output logic              out_seq_gap,
  output logic [31:0]       out_expected_seq,
  output logic [47:0]       out_entry_addr,
  output logic [31:0]       out_entry_size,
  output logic [31:0]       out_entry_seq,
  output logic              out_last
);
  import att_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic          in_ready;
  logic          out_free;
  push_t         push;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;
  logic          out_valid_r, out_valid_nxt;
  result_t       out_res_r;

  assign in_stall = !in_ready;

  att_mem #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  att_seq #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_seq      (in_seq),
    .in_addr     (in_addr),
    .in_new_addr (in_new_addr),
    .in_size     (in_size),
    .out_free    (out_free),
    .push        (push),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  // output register: free when empty or being taken this cycle
  assign out_free      = !out_valid_r || !out_stall;
  assign out_valid_nxt = (push.valid && out_free) ? 1'b1 :
                         (out_free ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && out_free) begin
      out_res_r <= push.res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_seq_gap      = out_res_r.seq_gap;
  assign out_expected_seq = out_res_r.expected_seq;
  assign out_entry_addr   = out_res_r.entry.addr;
  assign out_entry_size   = out_res_r.entry.size;
  assign out_entry_seq    = out_res_r.entry.seq;
  assign out_last         = out_res_r.last;

endmodule

`default_nettype wire

@@ bench/tb_allocation_tracking_table.sv @@
// Self-checking bench for the allocation tracking table: scoreboard and randomised request traffic.
module tb_allocation_tracking_table;
  import att_pkg::*;

  localparam int          DEPTH        = 32;
  localparam int          RANDOM_ITEMS = 280;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam logic [47:0] ADDR_MAX     = '1;

  typedef enum int unsigned {BURST_MIX, BURST_GROW, BURST_SHRINK} burst_mode_t;

  // Mirror of the live-chunk table plus the queue of results still owed
  class alloc_table_scoreboard_t #(int DEPTH = 32);
    logic [47:0] held_addr [DEPTH];
    logic [31:0] held_size [DEPTH];
    logic [31:0] held_seq  [DEPTH];
    int unsigned held_count;
    logic [31:0] seq_due;
    result_t     due_q [$];
    int unsigned errors, checked, requests, peak_held, full_hits, gap_hits;

    function new();
      held_count = 0;
      seq_due    = '0;
      errors     = 0;
      checked    = 0;
      requests   = 0;
      peak_held  = 0;
      full_hits  = 0;
      gap_hits   = 0;
    endfunction

    // Earliest entry holding this address, -1 if none
    function int find_addr(logic [47:0] a);
      for (int i = 0; i < held_count; i++)
        if (held_addr[i] == a) return i;
      return -1;
    endfunction

    function void push_outcome(logic [2:0] status, logic gap, logic [31:0] was_due,
                               logic [47:0] addr, logic [31:0] size, logic [31:0] seq,
                               logic last);
      result_t r;
      r.status       = status;
      r.seq_gap      = gap;
      r.expected_seq = was_due;
      r.entry.addr   = addr;
      r.entry.size   = size;
      r.entry.seq    = seq;
      r.last         = last;
      due_q.push_back(r);
    endfunction

    // Work out what an accepted request must produce and update the mirror
    function void note_request(logic [1:0] cmd, logic [31:0] seq, logic [47:0] addr,
                               logic [47:0] naddr, logic [31:0] size);
      logic [31:0] was_due;
      logic        gap;
      int          idx;
      int unsigned n;
      was_due = seq_due;
      requests++;
      if (cmd == CMD_REPORT) begin
        n = (held_count > MAX_RESULTS) ? MAX_RESULTS : held_count;
        if (n == 0)
          push_outcome(ST_EMPTY, 1'b0, was_due, '0, '0, '0, 1'b1);
        for (int i = 0; i < n; i++)
          push_outcome(ST_LEFTOVER, 1'b0, was_due, held_addr[i], held_size[i],
                       held_seq[i], i == n - 1);
        return;
      end
      gap     = (seq != was_due);
      seq_due = seq + 32'd1;
      if (gap) gap_hits++;
      case (cmd)
        CMD_ALLOC: begin
          idx = (addr == '0) ? -1 : find_addr(addr);
          if (addr == '0) begin
            push_outcome(ST_OK, gap, was_due, '0, '0, '0, 1'b1);
          end else if (idx >= 0) begin
            push_outcome(ST_DUP, gap, was_due, held_addr[idx], held_size[idx],
                         held_seq[idx], 1'b1);
          end else if (held_count >= DEPTH) begin
            full_hits++;
            push_outcome(ST_FULL, gap, was_due, addr, size, seq, 1'b1);
          end else begin
            held_addr[held_count] = addr;
            held_size[held_count] = size;
            held_seq[held_count]  = seq;
            held_count++;
            if (held_count > peak_held) peak_held = held_count;
            push_outcome(ST_OK, gap, was_due, '0, '0, '0, 1'b1);
          end
        end
        CMD_FREE: begin
          idx = (addr == '0) ? -1 : find_addr(addr);
          if (addr != '0 && idx < 0) begin
            push_outcome(ST_FREE_UNK, gap, was_due, addr, '0, seq, 1'b1);
          end else begin
            // close the gap behind the removed entry
            if (idx >= 0) begin
              for (int i = idx; i + 1 < held_count; i++) begin
                held_addr[i] = held_addr[i + 1];
                held_size[i] = held_size[i + 1];
                held_seq[i]  = held_seq[i + 1];
              end
              held_count--;
            end
            push_outcome(ST_OK, gap, was_due, '0, '0, '0, 1'b1);
          end
        end
        default: begin
          idx = (addr == '0 || naddr == '0) ? -1 : find_addr(addr);
          if (addr != '0 && naddr != '0 && idx < 0) begin
            push_outcome(ST_REAL_UNK, gap, was_due, addr, size, seq, 1'b1);
          end else begin
            // moved and resized in place, sequence kept
            if (idx >= 0) begin
              held_addr[idx] = naddr;
              held_size[idx] = size;
            end
            push_outcome(ST_OK, gap, was_due, '0, '0, '0, 1'b1);
          end
        end
      endcase
    endfunction

    function string show(result_t r);
      return $sformatf("st %0d gap %0b exp %h addr %h size %h seq %h last %b",
                       r.status, r.seq_gap, r.expected_seq, r.entry.addr,
                       r.entry.size, r.entry.seq, r.last);
    endfunction

    function void complain(string what, result_t want, result_t got);
      errors++;
      if (errors <= 10) begin
        $display("%s", what);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    endfunction

    // Compare one accepted result with the oldest one owed
    function void check_result(result_t got);
      result_t want;
      checked++;
      if (due_q.size() == 0) begin
        complain("mismatch: result with nothing outstanding", '0, got);
        return;
      end
      want = due_q.pop_front();
      if (got.status !== want.status || got.seq_gap !== want.seq_gap ||
          got.expected_seq !== want.expected_seq ||
          got.entry.addr !== want.entry.addr || got.entry.size !== want.entry.size ||
          got.entry.seq !== want.entry.seq || got.last !== want.last)
        complain("mismatch: result fields differ", want, got);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [31:0] in_seq;
  logic [47:0] in_addr;
  logic [47:0] in_new_addr;
  logic [31:0] in_size;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic        out_seq_gap;
  logic [31:0] out_expected_seq;
  logic [47:0] out_entry_addr;
  logic [31:0] out_entry_size;
  logic [31:0] out_entry_seq;
  logic        out_last;

  alloc_table_scoreboard_t #(DEPTH) sb;
  bit          quiet = 1'b0;
  int unsigned cycle_count = 0;

  allocation_tracking_table #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_seq           (in_seq),
    .in_addr          (in_addr),
    .in_new_addr      (in_new_addr),
    .in_size          (in_size),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_seq_gap      (out_seq_gap),
    .out_expected_seq (out_expected_seq),
    .out_entry_addr   (out_entry_addr),
    .out_entry_size   (out_entry_size),
    .out_entry_seq    (out_entry_seq),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.due_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [47:0] fresh_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    // some narrow addresses as well as full-width ones
    if ($urandom_range(0, 7) == 0) r = 64'($urandom_range(1, 255));
    if (r[47:0] == '0) r = 64'd1;
    return r[47:0];
  endfunction

  function automatic logic [47:0] held_or_fresh();
    if (sb.held_count == 0) return fresh_addr();
    return sb.held_addr[$urandom_range(0, sb.held_count - 1)];
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(1, 4096);
      default: return $urandom();
    endcase
  endfunction

  // Present one request after a random gap and hold it until accepted
  task automatic send_request(input logic [1:0] cmd, input logic [31:0] seq,
                              input logic [47:0] addr, input logic [47:0] naddr,
                              input logic [31:0] size);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_seq      <= seq;
    in_addr     <= addr;
    in_new_addr <= naddr;
    in_size     <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(cmd, seq, addr, naddr, size);
  endtask

  // Hold off new requests until every owed result has arrived
  task automatic drain_pause();
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  // One random request, mostly well formed, weighted by the burst mode
  task automatic random_request(input burst_mode_t mode);
    int unsigned roll;
    logic [1:0]  cmd;
    logic [47:0] addr, naddr;
    logic [31:0] seq;
    roll = $urandom_range(0, 99);
    case (mode)
      BURST_GROW:   cmd = roll < 75 ? CMD_ALLOC : roll < 85 ? CMD_FREE :
                          roll < 90 ? CMD_REALLOC : CMD_REPORT;
      BURST_SHRINK: cmd = roll < 15 ? CMD_ALLOC : roll < 70 ? CMD_FREE :
                          roll < 90 ? CMD_REALLOC : CMD_REPORT;
      default:      cmd = roll < 35 ? CMD_ALLOC : roll < 65 ? CMD_FREE :
                          roll < 85 ? CMD_REALLOC : CMD_REPORT;
    endcase
    roll = $urandom_range(0, 99);
    if (cmd == CMD_ALLOC)
      addr = roll < 75 ? fresh_addr() : roll < 93 ? held_or_fresh() : '0;
    else
      addr = roll < 72 ? held_or_fresh() : roll < 92 ? fresh_addr() : '0;
    roll  = $urandom_range(0, 99);
    naddr = roll < 70 ? fresh_addr() : roll < 85 ? held_or_fresh() : '0;
    // mostly in step, sometimes a jump to force a resync
    roll = $urandom_range(0, 19);
    seq  = roll < 17 ? sb.seq_due : roll < 19 ? $urandom() :
           sb.seq_due + $urandom_range(1, 3);
    send_request(cmd, seq, addr, naddr, pick_size());
  endtask

  // Result side: random stall before each result, then take it
  initial begin
    int unsigned hold;
    result_t     got;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got.status       = out_status;
      got.seq_gap      = out_seq_gap;
      got.expected_seq = out_expected_seq;
      got.entry.addr   = out_entry_addr;
      got.entry.size   = out_entry_size;
      got.entry.seq    = out_entry_seq;
      got.last         = out_last;
      sb.check_result(got);
    end
  end

  // Stimulus
  initial begin
    int unsigned issued;
    int unsigned burst_len;
    bit          filled;
    burst_mode_t mode;
    sb = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_cmd      <= CMD_ALLOC;
    in_seq      <= '0;
    in_addr     <= '0;
    in_new_addr <= '0;
    in_size     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed corners
    send_request(CMD_REPORT,  32'h0, 48'h0, 48'h0, 32'h0);                // empty table
    send_request(CMD_ALLOC,   32'h0, 48'h0, 48'h0, 32'h10);               // null alloc
    send_request(CMD_ALLOC,   32'h1, ADDR_MAX, 48'h0, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC,   32'h2, 48'h1, 48'h0, 32'h0);
    send_request(CMD_ALLOC,   32'h3, ADDR_MAX, 48'h0, 32'h20);            // duplicate
    send_request(CMD_FREE,    32'h4, 48'h8000_0000_0000, 48'h0, 32'h0);   // unknown free
    send_request(CMD_FREE,    32'h5, 48'h0, 48'h0, 32'h0);                // null free
    send_request(CMD_REALLOC, 32'h6, 48'h7777_0000_0001, 48'h40, 32'h99); // unknown old
    send_request(CMD_REALLOC, 32'h7, 48'h0, 48'h50, 32'h1);               // null old
    send_request(CMD_REALLOC, 32'h8, 48'h1, 48'h0, 32'h2);                // null new
    send_request(CMD_ALLOC,   32'h9, 48'h5555_5555_5555, 48'h0, 32'h5555_5555);
    send_request(CMD_REALLOC, 32'hA, 48'h1, 48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    // move onto an address already held: the pair share it
    send_request(CMD_REALLOC, 32'hB, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 32'h3);
    send_request(CMD_REPORT,  32'hFFFF_FFFF, ADDR_MAX, ADDR_MAX, 32'hFFFF_FFFF);
    send_request(CMD_FREE,    32'hC, 48'h5555_5555_5555, 48'h0, 32'h0);   // earliest goes
    send_request(CMD_ALLOC,   32'hFFFF_FFFF, 48'h2, 48'h0, 32'h1);        // sequence gap
    send_request(CMD_ALLOC,   32'h0, 48'h3, 48'h0, 32'h7);                // wraps to zero
    send_request(CMD_FREE,    32'h1, ADDR_MAX, 48'h0, 32'h0);             // head, compaction
    send_request(CMD_FREE,    32'h2, 48'h3, 48'h0, 32'h0);                // tail
    send_request(CMD_ALLOC,   32'h7FFF_FFFF, 48'h4, ADDR_MAX, 32'h0);     // gap, new ignored
    send_request(CMD_REPORT,  32'h0, 48'h0, 48'h0, 32'h0);
    drain_pause();

    // random bursts, with one pass that fills the table to the brim
    issued = 0;
    filled = 1'b0;
    while (issued < RANDOM_ITEMS) begin
      if (issued >= 60 && !filled) begin
        quiet = 1'b0;
        while (sb.held_count < DEPTH) begin
          send_request(CMD_ALLOC, sb.seq_due, fresh_addr(), fresh_addr(), pick_size());
          issued++;
        end
        repeat (3)
          send_request(CMD_ALLOC, sb.seq_due, fresh_addr(), '0, pick_size());
        send_request(CMD_ALLOC, sb.seq_due, held_or_fresh(), '0, pick_size());
        send_request(CMD_REPORT, $urandom(), fresh_addr(), fresh_addr(), $urandom());
        issued += 5;
        filled = 1'b1;
        drain_pause();
      end
      mode      = burst_mode_t'($urandom_range(0, 2));
      quiet     = ($urandom_range(0, 3) == 0);
      burst_len = $urandom_range(8, 30);
      repeat (burst_len) begin
        random_request(mode);
        issued++;
      end
    end
    quiet = 1'b0;

    // let everything owed arrive, then watch for stray results
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (4 * DEPTH + 16) @(posedge clk);
    sb.errors += sb.due_q.size();

    $display("summary: %0d requests, %0d results checked, peak occupancy %0d of %0d",
             sb.requests, sb.checked, sb.peak_held, DEPTH);
    $display("summary: %0d table-full rejections, %0d sequence gaps, %0d mismatches",
             sb.full_hits, sb.gap_hits, sb.errors);
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/att_pkg.sv
sv/att_mem.sv
sv/att_seq.sv
sv/allocation_tracking_table.sv
bench/tb_allocation_tracking_table.sv
